// File: rtl/ifsf_pkg.sv
package ifsf_pkg;

	localparam int unsigned MaxBytes = 9;
	localparam int unsigned CntW     = $clog2(MaxBytes + 1);

	typedef enum logic [2:0] {
		REG_FLAG      = 3'd0,
		REG_ESCAPE    = 3'd1,
		REG_FLAG_SUB  = 3'd2,
		REG_ESC_SUB   = 3'd3,
		REG_ADDRESS   = 3'd4,
		REG_CTRL_SEQ0 = 3'd5,
		REG_CTRL_SEQ1 = 3'd6
	} reg_idx_t;

	localparam logic [7:0] FlagReset    = 8'd126;
	localparam logic [7:0] EscapeReset  = 8'd125;
	localparam logic [7:0] FlagSubReset = 8'd94;
	localparam logic [7:0] EscSubReset  = 8'd93;
	localparam logic [7:0] AddrReset    = 8'd3;
	localparam logic [7:0] Ctrl0Reset   = 8'd0;
	localparam logic [7:0] Ctrl1Reset   = 8'd64;

	typedef struct packed {
		logic [7:0] flag;
		logic [7:0] escape;
		logic [7:0] flag_sub;
		logic [7:0] esc_sub;
		logic [7:0] address;
		logic [7:0] ctrl_seq0;
		logic [7:0] ctrl_seq1;
	} cfg_t;

	typedef struct packed {
		logic [7:0] payload;
		logic       final_byte;
		logic       seq;
	} item_t;

	typedef struct packed {
		logic [MaxBytes-1:0][7:0] data;
		logic [MaxBytes-1:0]      ends;
		logic [CntW-1:0]          count;
	} burst_t;

	typedef struct packed {
		logic [1:0][7:0] b;
		logic            two;
	} stuff_t;

	// escape a byte that collides with flag or escape; flag compare wins
	function automatic stuff_t stuff(input logic [7:0] v, input cfg_t c);
		stuff_t s;
		s.b[0] = c.escape;
		s.two  = 1'b1;
		if (v == c.flag) begin
			s.b[1] = c.flag_sub;
		end else if (v == c.escape) begin
			s.b[1] = c.esc_sub;
		end else begin
			s.b[0] = v;
			s.b[1] = v;
			s.two  = 1'b0;
		end
		return s;
	endfunction

endpackage

// File: rtl/info_frame_stuffing_framer_core.sv
// payload words go through item_s1, then the serializer burst register
// throughput: one line word per cycle while m_tready is high; a payload word yields
//   1 to 9 line words; the next burst loads as the last word is taken
// reset: arst_n clears frame state and pending words and restores the
//   default frame byte values
module info_frame_stuffing_framer_core
	import ifsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] payload_byte
	input  logic       s_tlast,
	input  logic       s_tuser,   // [0] sequence_bit
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] line_byte
	output logic       m_tlast,
	input  logic       cfg_we,
	input  logic [2:0] cfg_addr,
	input  logic [7:0] cfg_wdata
);

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       valid_s1;
	logic       inside_q;
	logic [7:0] check_q;
	logic       can_load;
	logic       load;
	burst_t     burst;
	logic       inside_next;
	logic [7:0] check_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag      <= FlagReset;
			cfg_q.escape    <= EscapeReset;
			cfg_q.flag_sub  <= FlagSubReset;
			cfg_q.esc_sub   <= EscSubReset;
			cfg_q.address   <= AddrReset;
			cfg_q.ctrl_seq0 <= Ctrl0Reset;
			cfg_q.ctrl_seq1 <= Ctrl1Reset;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FLAG:      cfg_q.flag      <= cfg_wdata;
				REG_ESCAPE:    cfg_q.escape    <= cfg_wdata;
				REG_FLAG_SUB:  cfg_q.flag_sub  <= cfg_wdata;
				REG_ESC_SUB:   cfg_q.esc_sub   <= cfg_wdata;
				REG_ADDRESS:   cfg_q.address   <= cfg_wdata;
				REG_CTRL_SEQ0: cfg_q.ctrl_seq0 <= cfg_wdata;
				REG_CTRL_SEQ1: cfg_q.ctrl_seq1 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign load     = valid_s1 && can_load;
	assign s_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.payload    <= s_tdata;
			item_s1.final_byte <= s_tlast;
			item_s1.seq        <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			check_q  <= 8'd0;
		end else if (load) begin
			inside_q <= inside_next;
			check_q  <= check_next;
		end
	end

	ifsf_build u_build (
		.item          (item_s1),
		.cfg           (cfg_q),
		.inside_frame  (inside_q),
		.running_check (check_q),
		.burst         (burst),
		.inside_next   (inside_next),
		.check_next    (check_next)
	);

	ifsf_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.burst    (burst),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: rtl/ifsf_build.sv
module ifsf_build
	import ifsf_pkg::*;
(
	input  item_t      item,
	input  cfg_t       cfg,
	input  logic       inside_frame,
	input  logic [7:0] running_check,
	output burst_t     burst,
	output logic       inside_next,
	output logic [7:0] check_next
);

	logic [7:0]      ctrl;
	logic [3:0][7:0] hdr;
	logic [7:0]      check_acc;
	stuff_t          ds;
	stuff_t          cs;
	logic [CntW-1:0] h_n;
	logic [CntW-1:0] d_n;
	logic [CntW-1:0] c_n;
	logic [CntW-1:0] total;

	always_comb begin
		ctrl   = item.seq ? cfg.ctrl_seq1 : cfg.ctrl_seq0;
		hdr[0] = cfg.flag;
		hdr[1] = cfg.address;
		hdr[2] = ctrl;
		hdr[3] = cfg.address ^ ctrl;

		// a new frame starts its check from zero
		check_acc = (inside_frame ? running_check : 8'd0) ^ item.payload;
		ds        = stuff(item.payload, cfg);
		cs        = stuff(check_acc, cfg);

		h_n   = inside_frame ? CntW'(0) : CntW'(4);
		d_n   = ds.two ? CntW'(2) : CntW'(1);
		c_n   = item.final_byte ? (cs.two ? CntW'(2) : CntW'(1)) : CntW'(0);
		total = h_n + d_n + c_n + CntW'(item.final_byte);

		inside_next = ~item.final_byte;
		check_next  = item.final_byte ? 8'd0 : check_acc;
	end

	always_comb begin
		burst.count = total;
		for (int i = 0; i < MaxBytes; i++) begin
			logic [CntW-1:0] idx;
			logic [CntW-1:0] j;
			logic [CntW-1:0] k;
			idx = CntW'(i);
			j   = idx - h_n;
			k   = j - d_n;
			if (idx < h_n) begin
				burst.data[i] = hdr[idx[1:0]];
			end else if (j < d_n) begin
				burst.data[i] = ds.b[j[0]];
			end else if (k < c_n) begin
				burst.data[i] = cs.b[k[0]];
			end else begin
				burst.data[i] = cfg.flag;
			end
			burst.ends[i] = item.final_byte && (idx == total - CntW'(1));
		end
	end

endmodule

// File: rtl/ifsf_serializer.sv
module ifsf_serializer
	import ifsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  burst_t     burst,
	output logic       can_load,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] line_byte
	output logic       m_tlast
);

	logic [MaxBytes-1:0][7:0] data_q;
	logic [MaxBytes-1:0]      ends_q;
	logic [CntW-1:0]          count_q;
	logic                     taken;

	assign m_tvalid = (count_q != '0);
	assign taken    = m_tvalid && m_tready;
	assign can_load = (count_q == '0) || ((count_q == CntW'(1)) && m_tready);
	assign m_tdata  = data_q[0];
	assign m_tlast  = ends_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= burst.count;
		end else if (taken) begin
			count_q <= count_q - CntW'(1);
		end
	end

	// shift toward slot zero, one word per handshake
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= burst.data;
			ends_q <= burst.ends;
		end else if (taken) begin
			for (int i = 0; i < MaxBytes - 1; i++) begin
				data_q[i] <= data_q[i+1];
				ends_q[i] <= ends_q[i+1];
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxBytes))
		else $error("burst count out of range");

	a_last_closes_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> count_q == CntW'(1))
		else $error("closing flag not at end of burst");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (count_q == '0) || (count_q == CntW'(1) && taken))
		else $error("burst loaded over pending words");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !load |=> $stable(count_q))
		else $error("burst count moved while stalled");

endmodule
